// ----- rtl/cih_pkg.sv -----
// Shared types, constants and helpers of the constant intern hash table.
`default_nettype none

package cih_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 128;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int POOL_DEPTH  = (TABLE_SLOTS * 3) / 4;
    localparam int PIDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam int PROBE_W     = SLOT_W + 1;

    // Field widths
    localparam int KIND_W   = 8;
    localparam int RAW_W    = 64;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 2;
    localparam int POOL_W   = KIND_W + RAW_W;

    // Hash constants
    localparam logic [63:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL    = 64'hFF51_AFD7_ED55_8CCD;
    localparam int          MIX_SHIFT  = 33;

    // Slot reduction: hash mod TABLE_SLOTS by reciprocal multiply plus one correction
    localparam int          RECIP_SHIFT = 32 + SLOT_W;
    localparam logic [32:0] RECIP_MUL   = 33'((64'd1 << RECIP_SHIFT) / TABLE_SLOTS);
    localparam logic [31:0] SLOTS_32    = 32'(TABLE_SLOTS);

    localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [PROBE_W-1:0] PROBE_LIMIT = PROBE_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]   POOL_LIMIT  = CNT_W'(POOL_DEPTH);

    // Result queue depth
    localparam int          RES_DEPTH = 2;
    localparam logic [1:0]  RES_FULL  = 2'(RES_DEPTH);

    typedef enum logic
    {
        OP_INTERN,
        OP_CLEAR
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_FOUND,
        ST_INSERTED,
        ST_FULL,
        ST_CLEARED
    } status_t;

    typedef enum logic [1:0]
    {
        BE_IDLE,
        BE_SLOT,
        BE_POOL
    } be_state_t;

    typedef struct packed
    {
        logic              op;
        logic [KIND_W-1:0] value_kind;
        logic [RAW_W-1:0]  raw_bits;
    } fe_key_t;

    typedef struct packed
    {
        logic              op;
        logic [KIND_W-1:0] value_kind;
        logic [RAW_W-1:0]  raw_bits;
        logic [SLOT_W-1:0] home;
    } fe_item_t;

    typedef struct packed
    {
        logic [INDEX_W-1:0] const_index;
        status_t            status;
    } res_t;

    function automatic logic [INDEX_W-1:0] pidx_to_index(input logic [PIDX_W-1:0] p);
        logic [PIDX_W+INDEX_W-1:0] ext;
        ext = {{INDEX_W{1'b0}}, p};
        return ext[INDEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cih_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cih_front.sv -----
// Front end: accepts items and computes the home slot through a hash pipeline.
`default_nettype none

module cih_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 op,
    input  wire logic [7:0]           value_kind,
    input  wire logic [63:0]          raw_bits,
    input  wire logic                 q_full,
    output logic                      q_push,
    output cih_pkg::fe_item_t         q_item
);

    import cih_pkg::*;

    localparam int STAGES = 8;

    logic                 adv;
    logic [STAGES-1:0]    valid_reg;
    fe_key_t              key_reg [STAGES];

    logic [63:0]          golden_prod;
    logic [63:0]          mix_in;
    logic [63:0]          mix1_reg;
    logic [63:0]          lo_lo_reg;
    logic [31:0]          lo_hi_reg;
    logic [31:0]          mix_hi_reg;
    logic [63:0]          lo_lo3_reg;
    logic [31:0]          lo_hi3_reg;
    logic [31:0]          hi_lo_reg;
    logic [63:0]          prod;
    logic [63:0]          hash;
    logic [31:0]          hash_lo_reg;
    logic [64:0]          recip_prod;
    logic [31:0]          quot_reg;
    logic [31:0]          hash_lo5_reg;
    logic [31:0]          qt_reg;
    logic [31:0]          hash_lo6_reg;
    logic [31:0]          rem;
    logic [31:0]          rem_fix;
    logic [SLOT_W-1:0]    home_reg;

    // The whole pipeline holds while the queue is full
    assign adv  = !q_full;
    assign full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], push};
        end
    end

    assign golden_prod = 64'(key_reg[0].value_kind * GOLDEN_MUL);
    assign mix_in      = key_reg[0].raw_bits ^ golden_prod;

    // 64-bit low product split into three 32x32 partial products
    assign prod = lo_lo3_reg + {lo_hi3_reg + hi_lo_reg, 32'b0};
    assign hash = prod ^ (prod >> MIX_SHIFT);

    assign recip_prod = {33'b0, hash_lo_reg} * {32'b0, RECIP_MUL};

    assign rem     = hash_lo6_reg - qt_reg;
    assign rem_fix = (rem >= SLOTS_32) ? rem - SLOTS_32 : rem;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg[0] <= '{op: op, value_kind: value_kind, raw_bits: raw_bits};
            for (int i = 1; i < STAGES; i++)
            begin
                key_reg[i] <= key_reg[i-1];
            end

            mix1_reg     <= mix_in ^ (mix_in >> MIX_SHIFT);

            lo_lo_reg    <= {32'b0, mix1_reg[31:0]} * {32'b0, MIX_MUL[31:0]};
            lo_hi_reg    <= 32'(mix1_reg[31:0] * MIX_MUL[63:32]);
            mix_hi_reg   <= mix1_reg[63:32];

            hi_lo_reg    <= 32'(mix_hi_reg * MIX_MUL[31:0]);
            lo_lo3_reg   <= lo_lo_reg;
            lo_hi3_reg   <= lo_hi_reg;

            hash_lo_reg  <= hash[31:0];

            quot_reg     <= 32'(recip_prod >> RECIP_SHIFT);
            hash_lo5_reg <= hash_lo_reg;

            qt_reg       <= 32'(quot_reg * SLOTS_32);
            hash_lo6_reg <= hash_lo5_reg;

            home_reg     <= rem_fix[SLOT_W-1:0];
        end
    end

    assign q_push = adv && valid_reg[STAGES-1];

    always_comb
    begin
        q_item.op         = key_reg[STAGES-1].op;
        q_item.value_kind = key_reg[STAGES-1].value_kind;
        q_item.raw_bits   = key_reg[STAGES-1].raw_bits;
        q_item.home       = home_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/cih_queue.sv -----
// Two-entry queue of classified items between the front and back ends.
`default_nettype none

module cih_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cih_pkg::fe_item_t  push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output cih_pkg::fe_item_t       head
);

    import cih_pkg::*;

    fe_item_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cih_back.sv -----
// Back end: probes the slot table, compares against the pool, inserts and queues results.
`default_nettype none

module cih_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire cih_pkg::fe_item_t  q_item,
    output logic                    q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic [6:0]              const_index,
    output logic [1:0]              status
);

    import cih_pkg::*;

    be_state_t              state_reg, state_next;
    logic [SLOT_W-1:0]      s_reg, s_next, s_inc;
    logic [PROBE_W-1:0]     n_reg, n_next, n_inc;
    logic [PIDX_W-1:0]      ci_reg, ci_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [RAW_W-1:0]       raw_reg, raw_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TABLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;

    logic                   slot_we;
    logic                   slot_re;
    logic [SLOT_W-1:0]      slot_raddr;
    logic [PIDX_W-1:0]      slot_rdata;
    logic                   pool_we;
    logic                   pool_re;
    logic [POOL_W-1:0]      pool_rdata;

    logic                   res_push;
    res_t                   res_item;
    res_t                   res_mem_reg [RES_DEPTH];
    logic                   res_wr_reg;
    logic                   res_rd_reg;
    logic [1:0]             res_cnt_reg;
    logic                   res_pop;

    cih_ram #(
        .WIDTH (PIDX_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (s_reg),
        .wdata (count_reg[PIDX_W-1:0]),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    cih_ram #(
        .WIDTH (POOL_W),
        .DEPTH (POOL_DEPTH)
    ) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (count_reg[PIDX_W-1:0]),
        .wdata ({kind_reg, raw_reg}),
        .re    (pool_re),
        .raddr (slot_rdata),
        .rdata (pool_rdata)
    );

    assign s_inc = (s_reg == SLOT_LAST) ? '0 : s_reg + 1'b1;
    assign n_inc = n_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BE_IDLE;
            count_reg      <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        n_reg    <= n_next;
        ci_reg   <= ci_next;
        kind_reg <= kind_next;
        raw_reg  <= raw_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        ci_next         = ci_reg;
        kind_next       = kind_reg;
        raw_next        = raw_reg;
        count_next      = count_reg;
        slot_valid_next = slot_valid_reg;
        q_pop           = 1'b0;
        slot_re         = 1'b0;
        slot_raddr      = s_reg;
        slot_we         = 1'b0;
        pool_re         = 1'b0;
        pool_we         = 1'b0;
        res_push        = 1'b0;
        res_item        = '{const_index: '0, status: ST_FOUND};

        unique case (state_reg)
            BE_IDLE:
            begin
                // Start only with room left for the result
                if (q_valid && res_cnt_reg != RES_FULL)
                begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_CLEAR)
                    begin
                        slot_valid_next = '0;
                        count_next      = '0;
                        res_push        = 1'b1;
                        res_item.status = ST_CLEARED;
                    end
                    else
                    begin
                        slot_re    = 1'b1;
                        slot_raddr = q_item.home;
                        s_next     = q_item.home;
                        n_next     = '0;
                        kind_next  = q_item.value_kind;
                        raw_next   = q_item.raw_bits;
                        state_next = BE_SLOT;
                    end
                end
            end

            BE_SLOT:
            begin
                if (!slot_valid_reg[s_reg])
                begin
                    res_push   = 1'b1;
                    state_next = BE_IDLE;
                    if (count_reg == POOL_LIMIT)
                    begin
                        res_item.status = ST_FULL;
                    end
                    else
                    begin
                        slot_we                = 1'b1;
                        pool_we                = 1'b1;
                        slot_valid_next[s_reg] = 1'b1;
                        count_next             = count_reg + 1'b1;
                        res_item.const_index   = pidx_to_index(count_reg[PIDX_W-1:0]);
                        res_item.status        = ST_INSERTED;
                    end
                end
                else
                begin
                    pool_re    = 1'b1;
                    ci_next    = slot_rdata;
                    state_next = BE_POOL;
                end
            end

            BE_POOL:
            begin
                if (pool_rdata == {kind_reg, raw_reg})
                begin
                    res_push             = 1'b1;
                    res_item.const_index = pidx_to_index(ci_reg);
                    res_item.status      = ST_FOUND;
                    state_next           = BE_IDLE;
                end
                else if (n_inc == PROBE_LIMIT && slot_valid_reg[s_inc])
                begin
                    // Probe bound hit on an occupied slot
                    res_push        = 1'b1;
                    res_item.status = ST_FULL;
                    state_next      = BE_IDLE;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = s_inc;
                    s_next     = s_inc;
                    n_next     = n_inc;
                    state_next = BE_SLOT;
                end
            end

            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    // Result queue
    assign empty       = (res_cnt_reg == 2'd0);
    assign res_pop     = pop && !empty;
    assign const_index = res_mem_reg[res_rd_reg].const_index;
    assign status      = res_mem_reg[res_rd_reg].status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                res_wr_reg <= !res_wr_reg;
            end
            if (res_pop)
            begin
                res_rd_reg <= !res_rd_reg;
            end
            if (res_push && !res_pop)
            begin
                res_cnt_reg <= res_cnt_reg + 2'd1;
            end
            else if (res_pop && !res_push)
            begin
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_reg] <= res_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/constant_intern_hash_table.sv -----
// Flow: an accepted beat passes the 8-stage hash front end and the two-entry queue; the
// back end answers a clear from its idle state, an insert from the slot state, and a hit
// from the pool state; each probe reads the slot RAM and then the pool RAM. The back end
// takes one item at a time and starts the next only when room is left for its result.
// Reset: asynchronous, active low; slot valid bits, pool count and queues clear at once,
// no clearing pass, so the block accepts items as soon as reset is released.
`default_nettype none

module constant_intern_hash_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        op,
    input  wire logic [7:0]  value_kind,
    input  wire logic [63:0] raw_bits,
    output logic             empty,
    input  wire logic        pop,
    output logic [6:0]       const_index,
    output logic [1:0]       status
);

    import cih_pkg::*;

    logic     q_full;
    logic     q_push;
    fe_item_t q_push_item;
    logic     q_pop;
    logic     q_valid;
    fe_item_t q_head;

    cih_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .value_kind (value_kind),
        .raw_bits   (raw_bits),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_push_item)
    );

    cih_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    cih_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .const_index (const_index),
        .status      (status)
    );

endmodule

`default_nettype wire

// ----- rtl/cih_checker.sv -----
// Port-level checks for the constant intern hash table, bound to the top level.
`default_nettype none

module cih_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [6:0]  const_index,
    input wire logic [1:0]  status
);

    import cih_pkg::*;

    // A clear result carries index zero
    a_clear_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_CLEARED) |-> (const_index == '0))
        else $error("clear result with nonzero index");

    // A refused insert carries index zero
    a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FULL) |-> (const_index == '0))
        else $error("full result with nonzero index");

    // Found or inserted indexes stay inside the pool
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_FOUND || status == ST_INSERTED))
            |-> (int'(const_index) < POOL_DEPTH))
        else $error("result index outside the pool");

    // A waiting result beat holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(const_index) && $stable(status)))
        else $error("waiting result changed before pop");

endmodule

bind constant_intern_hash_table cih_checker u_cih_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .const_index (const_index),
    .status      (status)
);

`default_nettype wire

// ----- tb/tb_constant_intern_hash_table.sv -----
// Testbench for the constant intern hash table: directed rows, then random beats, self-checked.
`timescale 1ns / 100ps

module tb_constant_intern_hash_table;

    import cih_pkg::*;

    localparam int RANDOM_ITEMS   = 1625;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_REPORTED   = 10;

    typedef struct packed
    {
        logic [KIND_W-1:0] kind;
        logic [RAW_W-1:0]  raw;
    } const_key_t;

    typedef struct
    {
        op_t        op;
        const_key_t key;
        bit         has_exp;
        res_t       exp;
    } stim_row_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              push       = 1'b0;
    logic              op         = 1'b0;
    logic [7:0]        value_kind = '0;
    logic [63:0]       raw_bits   = '0;
    logic              pop        = 1'b0;
    logic              full;
    logic              empty;
    logic [6:0]        const_index;
    logic [1:0]        status;

    // Typed expectation travels with the beat that carries it
    bit                drv_has_exp = 1'b0;
    res_t              drv_exp     = '0;

    // Shadow copy of the table and pool
    int                shadow_slot [TABLE_SLOTS];
    logic [KIND_W-1:0] shadow_kind [POOL_DEPTH];
    logic [RAW_W-1:0]  shadow_raw  [POOL_DEPTH];
    int                shadow_count = 0;

    res_t              awaited_results[$];
    stim_row_t         directed_rows[$];
    const_key_t        working_keys[$];

    int                mismatches   = 0;
    int                beats_in     = 0;
    int                beats_out    = 0;
    int                held_cycles  = 0;
    int                holds_done   = 0;
    int                random_sent  = 0;
    int                burst_left   = 1;
    int                idle_cycles  = 0;
    int                status_seen [4];

    constant_intern_hash_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .value_kind  (value_kind),
        .raw_bits    (raw_bits),
        .empty       (empty),
        .pop         (pop),
        .const_index (const_index),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [SLOT_W-1:0] home_of(input logic [KIND_W-1:0] kind,
                                                  input logic [RAW_W-1:0] raw);
        logic [63:0] h;
        h = raw ^ (64'(kind) * GOLDEN_MUL);
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_MUL;
        h = h ^ (h >> MIX_SHIFT);
        return SLOT_W'(h[31:0] % SLOTS_32);
    endfunction

    // Walk the probe chain of the shadow table and update it as the block would
    function automatic void intern_lookup(input op_t o, input logic [KIND_W-1:0] kind,
                                          input logic [RAW_W-1:0] raw,
                                          output logic [INDEX_W-1:0] idx,
                                          output status_t st);
        int s;
        int ci;
        idx = '0;
        if (o == OP_CLEAR)
        begin
            foreach (shadow_slot[i])
                shadow_slot[i] = 0;
            shadow_count = 0;
            st = ST_CLEARED;
            return;
        end
        s = int'(home_of(kind, raw));
        for (int n = 0; n < TABLE_SLOTS && shadow_slot[s] != 0; n++)
        begin
            ci = shadow_slot[s] - 1;
            if (ci < POOL_DEPTH && shadow_kind[ci] == kind && shadow_raw[ci] == raw)
            begin
                idx = INDEX_W'(ci);
                st  = ST_FOUND;
                return;
            end
            s = (s == TABLE_SLOTS - 1) ? 0 : s + 1;
        end
        if (shadow_count >= POOL_DEPTH || shadow_slot[s] != 0)
        begin
            st = ST_FULL;
            return;
        end
        shadow_kind[shadow_count] = kind;
        shadow_raw[shadow_count]  = raw;
        shadow_slot[s]            = shadow_count + 1;
        idx                       = INDEX_W'(shadow_count);
        shadow_count              = shadow_count + 1;
        st                        = ST_INSERTED;
    endfunction

    function automatic const_key_t key_with_home(input logic [SLOT_W-1:0] slot);
        const_key_t k;
        do
        begin
            k.kind = 8'($urandom);
            k.raw  = {$urandom, $urandom};
        end
        while (home_of(k.kind, k.raw) != slot);
        return k;
    endfunction

    function automatic const_key_t fresh_key(input bit allow_small);
        const_key_t k;
        if (allow_small && $urandom_range(0, 3) == 0)
        begin
            k.kind = 8'($urandom_range(0, 3));
            k.raw  = 64'($urandom_range(0, 15));
        end
        else
        begin
            k.kind = 8'($urandom);
            k.raw  = {$urandom, $urandom};
        end
        return k;
    endfunction

    // Mix of repeats, new keys, one-bit neighbors and keys on an occupied home slot
    function automatic const_key_t next_function_key();
        int         r;
        const_key_t k;
        r = $urandom_range(0, 99);
        if (working_keys.size() == 0 || r < 35)
            return fresh_key(1'b1);
        k = working_keys[$urandom_range(0, working_keys.size() - 1)];
        if (r >= 90)
            k = key_with_home(home_of(k.kind, k.raw));
        else if (r >= 80)
            k = k ^ (72'(1) << $urandom_range(0, 71));
        return k;
    endfunction

    function automatic void add_row(input op_t o, input const_key_t key, input bit has_exp,
                                    input logic [INDEX_W-1:0] idx, input status_t st);
        stim_row_t row;
        row.op                = o;
        row.key               = key;
        row.has_exp           = has_exp;
        row.exp.const_index   = idx;
        row.exp.status        = st;
        directed_rows.push_back(row);
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("MISMATCH: %s", msg);
    endtask

    // Offer one beat, hold it until accepted, then maybe open a gap
    task automatic send_beat(input op_t o, input const_key_t key, input bit has_exp,
                             input res_t ex);
        push        <= 1'b1;
        op          <= o;
        value_kind  <= key.kind;
        raw_bits    <= key.raw;
        drv_has_exp <= has_exp;
        drv_exp     <= ex;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        if (burst_left <= 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 200);
            else
                burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic emit(input op_t o, input const_key_t key);
        send_beat(o, key, 1'b0, '0);
        if (o == OP_INTERN)
            working_keys.push_back(key);
        random_sent++;
    endtask

    // Overfill the pool, then keep hitting it with old and new keys
    task automatic flood();
        emit(OP_CLEAR, fresh_key(1'b0));
        working_keys.delete();
        repeat (120) emit(OP_INTERN, fresh_key(1'b0));
        repeat (40) emit(OP_INTERN, next_function_key());
    endtask

    always @(posedge clk)
    begin : monitor
        res_t                want;
        logic [INDEX_W-1:0]  p_idx;
        status_t             p_st;
        if (rst_n)
        begin
            if (push && !full)
            begin
                intern_lookup(op_t'(op), value_kind, raw_bits, p_idx, p_st);
                if (drv_has_exp)
                    want = drv_exp;
                else
                begin
                    want.const_index = p_idx;
                    want.status      = p_st;
                end
                awaited_results.push_back(want);
                beats_in++;
            end
            if (push && full)
                held_cycles++;
            if (pop && !empty)
            begin
                beats_out++;
                status_seen[status]++;
                if (awaited_results.size() == 0)
                    note_failure($sformatf("unexpected result index %0d status %0d",
                                           const_index, status));
                else
                begin
                    want = awaited_results.pop_front();
                    if (const_index !== want.const_index || status !== want.status)
                        note_failure($sformatf(
                            "result %0d: expected index %0d status %s, got index %0d status %0d",
                            beats_out, want.const_index, want.status.name(), const_index,
                            status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("constant_intern_hash_table verification failed");
                $finish;
            end
        end
    end

    // Receiver: switches among random duty patterns, with two long hold-offs
    initial
    begin
        int phase;
        int mode;
        int next_hold;
        phase     = 0;
        mode      = 0;
        next_hold = 300;
        forever
        begin
            @(posedge clk);
            if (holds_done < 2 && beats_in >= next_hold)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
                next_hold = next_hold + 900;
            end
            else
            begin
                if (phase % 32 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= phase[0];
                endcase
                phase++;
            end
        end
    end

    initial
    begin
        const_key_t wrap_key [4];
        const_key_t k;
        const_key_t ones_ones;
        const_key_t zero_zero;
        const_key_t zero_ones;
        const_key_t ones_zero;
        int         r;
        res_t       none;

        none      = '0;
        zero_zero = {8'h00, 64'h0};
        ones_ones = {8'hFF, 64'hFFFF_FFFF_FFFF_FFFF};
        zero_ones = {8'h00, 64'hFFFF_FFFF_FFFF_FFFF};
        ones_zero = {8'hFF, 64'h0};
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (shadow_slot[i])
            shadow_slot[i] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(OP_INTERN, zero_zero, 1'b1, 7'd0, ST_INSERTED);
        add_row(OP_INTERN, zero_zero, 1'b1, 7'd0, ST_FOUND);
        add_row(OP_INTERN, ones_ones, 1'b1, 7'd1, ST_INSERTED);
        // same raw bits, other kind: a distinct constant
        add_row(OP_INTERN, zero_ones, 1'b1, 7'd2, ST_INSERTED);
        add_row(OP_INTERN, ones_zero, 1'b1, 7'd3, ST_INSERTED);
        add_row(OP_INTERN, ones_ones, 1'b1, 7'd1, ST_FOUND);
        add_row(OP_CLEAR, ones_ones, 1'b1, 7'd0, ST_CLEARED);
        add_row(OP_INTERN, ones_ones, 1'b1, 7'd0, ST_INSERTED);
        add_row(OP_INTERN, zero_zero, 1'b1, 7'd1, ST_INSERTED);
        // chain on the last slot wraps to slot 0
        foreach (wrap_key[i])
        begin
            wrap_key[i] = key_with_home(SLOT_LAST);
            add_row(OP_INTERN, wrap_key[i], 1'b0, 7'd0, ST_FOUND);
        end
        add_row(OP_INTERN, wrap_key[3], 1'b0, 7'd0, ST_FOUND);
        add_row(OP_INTERN, {8'h55, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, 7'd0, ST_FOUND);
        add_row(OP_INTERN, {8'hAA, 64'h5555_5555_5555_5555}, 1'b0, 7'd0, ST_FOUND);
        k = key_with_home('0);
        add_row(OP_INTERN, k, 1'b0, 7'd0, ST_FOUND);
        add_row(OP_INTERN, k, 1'b0, 7'd0, ST_FOUND);
        add_row(OP_INTERN, {8'h80, 64'h8000_0000_0000_0000}, 1'b0, 7'd0, ST_FOUND);
        add_row(OP_INTERN, {8'h01, 64'h1}, 1'b0, 7'd0, ST_FOUND);
        add_row(OP_CLEAR, zero_zero, 1'b1, 7'd0, ST_CLEARED);
        add_row(OP_INTERN, zero_zero, 1'b1, 7'd0, ST_INSERTED);
        add_row(OP_CLEAR, zero_zero, 1'b1, 7'd0, ST_CLEARED);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].key, directed_rows[i].has_exp,
                      directed_rows[i].has_exp ? directed_rows[i].exp : none);

        // fill the pool early so full status and hits on a full pool come up
        flood();
        while (random_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                flood();
            else if (r < 20)
            begin
                repeat ($urandom_range(1, 6))
                    emit(op_t'($urandom_range(0, 1)), fresh_key(1'b1));
            end
            else
            begin
                if ($urandom_range(0, 7) != 0)
                begin
                    emit(OP_CLEAR, fresh_key(1'b1));
                    working_keys.delete();
                end
                repeat ($urandom_range(10, 140))
                    emit(OP_INTERN, next_function_key());
            end
        end
        push <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", awaited_results.size()));

        $display("covered %0d beats in (%0d directed), %0d out, %0d cycles with input full",
                 beats_in, directed_rows.size(), beats_out, held_cycles);
        $display("statuses seen: %0d found, %0d inserted, %0d pool full, %0d cleared",
                 status_seen[ST_FOUND], status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_CLEARED]);
        if (mismatches == 0)
            $display("constant_intern_hash_table verification clean");
        else
            $display("constant_intern_hash_table verification failed");
        $finish;
    end

endmodule
